FILE: hdl/fhl_pkg.sv
// Shared constants and helpers for the floating horizon line clipper.
// Used by floating_horizon_line_clip; depends on nothing else.
`timescale 1ns / 1ps
package fhl_pkg;
  localparam int COLUMNS    = 64;
  localparam int LEVEL_BITS = 11;
  localparam int FW         = 11;               // width of coordinate and level fields
  localparam int CW         = 6;                // width of the column result fields
  localparam int CAW        = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int LVL_MAX    = (1 << (LEVEL_BITS - 1)) - 1;
  localparam int LVL_MIN    = -(1 << (LEVEL_BITS - 1));
  localparam int LVL_HI     = (LVL_MAX > (1 << (FW - 1)) - 1) ? (1 << (FW - 1)) - 1 : LVL_MAX;
  localparam int LVL_LO     = (LVL_MIN < -(1 << (FW - 1))) ? -(1 << (FW - 1)) : LVL_MIN;

  typedef logic signed [FW-1:0] level_t;

  function automatic level_t clamp_level(input level_t v);
    level_t r;
    r = v;
    if (int'(v) > LVL_HI) r = level_t'(LVL_HI);
    if (int'(v) < LVL_LO) r = level_t'(LVL_LO);
    return r;
  endfunction

  function automatic level_t lmin(input level_t a, input level_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic level_t lmax(input level_t a, input level_t b);
    return (a > b) ? a : b;
  endfunction
endpackage

FILE: hdl/floating_horizon_line_clip.sv
// Floating horizon hidden-line clipper: top level with sequencer and datapath.
// Depends on fhl_pkg and fhl_ram.
`timescale 1ns / 1ps
// Usage: an item is accepted when start is high and busy is low. An item of kind
// clear resets both horizons in that same edge and gives no result; busy stays low.
// A segment item makes the block busy while it walks its columns. Each visited
// in-grid column gives one result, shown for exactly one cycle with out_strobe
// high; out_last marks the final result of the item. A segment entirely off the
// grid gives one result with all fields zero but out_last, and a vertical
// segment gives a single result.
// A sloped segment first runs two 28-step restoring divisions on the shared
// divider (initial level and per-column step), then handles each column as a
// horizon RAM read followed by a compare and write back. Results cannot be
// held off: the receiver must take each one in its strobe cycle. The next item
// may be accepted in the cycle that shows the last result. Reset clears the
// horizons through per-entry valid bits at once and sets last_column to 63; no
// clearing pass is needed.
// The configuration register last_column sits at byte address 0 on the APB port.
module floating_horizon_line_clip (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_kind,
  input  logic signed [10:0]    in_start_column,
  input  logic signed [10:0]    in_start_level,
  input  logic signed [10:0]    in_end_column,
  input  logic signed [10:0]    in_end_level,
  output logic                  out_strobe,
  output logic [5:0]            out_column,
  output logic [5:0]            out_from_column,
  output logic                  out_lower_draw,
  output logic signed [10:0]    out_lower_from,
  output logic signed [10:0]    out_lower_to,
  output logic                  out_upper_draw,
  output logic signed [10:0]    out_upper_from,
  output logic signed [10:0]    out_upper_to,
  output logic                  out_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import fhl_pkg::*;

  localparam int DW  = FW + 1;          // span, slope delta, column offset
  localparam int MW  = 2 * (DW + 1);    // product width
  localparam int NW  = MW + 2;          // numerator and dividend width
  localparam int RW  = DW + 1;          // divisor and remainder width
  localparam int QW  = FW + 3;          // quotient width
  localparam int KW  = $clog2(NW + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_MUL2  = 4'd3;
  localparam logic [3:0] S_LOAD  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_DFIX  = 4'd6;
  localparam logic [3:0] S_RD    = 4'd7;
  localparam logic [3:0] S_COL   = 4'd8;

  localparam logic [1:0] SIDE_NONE = 2'd0;
  localparam logic [1:0] SIDE_IN   = 2'd1;
  localparam logic [1:0] SIDE_OUT  = 2'd2;

  logic [3:0] state_r, state_nxt;
  logic [CW-1:0] last_column_r;

  // Latched item.
  logic signed [FW-1:0] i1_r, i2_r;
  level_t j1_r, j2_r;

  // Geometry of the walk.
  logic [DW-1:0] d_r, k_r;
  logic signed [DW-1:0] dl_r;
  logic inc_neg_r, vert_r, first_r;
  logic [CAW-1:0] c_r, ce_r;

  // Interpolation state.
  logic signed [MW-1:0] prod_r;
  logic signed [NW-1:0] num_r, n_r;
  logic signed [QW-1:0] q_r, qs_r;
  logic [RW-1:0] r_r, rs_r;

  // Shared divider.
  logic [NW-1:0] dq_r;
  logic [RW:0] drem_r;
  logic dneg_r, dsel_r;
  logic [KW-1:0] dcnt_r;

  // Walk sides and previous column.
  logic [1:0] lb_r, ub_r;
  level_t pj_r, prev_l_r, prev_k_r;

  // Horizon stores with valid bits.
  logic [COLUMNS-1:0] lval_r, uval_r;
  logic lvq_r, uvq_r;
  logic [FW-1:0] lram_q, uram_q;
  logic ram_we;
  level_t l2, k2;

  logic accept;
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // ------------------------------------------------------------------ config
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - CW){1'b0}}, last_column_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_column_r <= CW'(63);
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      last_column_r <= pwdata[CW-1:0];
    end
  end

  // ---------------------------------------------------------------- geometry
  logic [CW-1:0] lastc;
  logic signed [DW-1:0] i1e, i2e, lce, cs_s, ce_s, k_s, d_s;
  logic inc_pos, in_grid;

  always_comb begin
    lastc   = (int'(last_column_r) > COLUMNS - 1) ? CW'(COLUMNS - 1) : last_column_r;
    i1e     = DW'(i1_r);
    i2e     = DW'(i2_r);
    lce     = $signed({{(DW - CW){1'b0}}, lastc});
    inc_pos = (i1e < i2e);
    if (i1e == i2e) begin
      in_grid = (i1e >= 0) && (i1e <= lce);
      cs_s    = i1e;
      ce_s    = i1e;
    end else if (inc_pos) begin
      in_grid = (i2e >= 0) && (i1e <= lce);
      cs_s    = (i1e < 0) ? '0 : i1e;
      ce_s    = (i2e > lce) ? lce : i2e;
    end else begin
      in_grid = (i1e >= 0) && (i2e <= lce);
      cs_s    = (i1e > lce) ? lce : i1e;
      ce_s    = (i2e < 0) ? '0 : i2e;
    end
    k_s = inc_pos ? (cs_s - i1e) : (i1e - cs_s);
    d_s = inc_pos ? (i2e - i1e) : (i1e - i2e);
  end

  // ------------------------------------------------------- shared multiplier
  logic signed [DW:0] mul_a, mul_b;
  logic signed [MW-1:0] mul_p;

  always_comb begin
    if (state_r == S_MUL1) begin
      mul_a = (DW + 1)'(j1_r);
      mul_b = $signed({1'b0, d_r});
    end else begin
      mul_a = (DW + 1)'(dl_r);
      mul_b = $signed({1'b0, k_r});
    end
    mul_p = mul_a * mul_b;
  end

  // ---------------------------------------------------------- divider step
  logic [RW:0] rem_sh, rem_sub;
  logic rem_ge;
  logic [RW-1:0] dvs;
  logic signed [NW-1:0] x_val, dl2, qfix;
  logic [RW-1:0] rfix;
  logic rnz;

  always_comb begin
    dvs     = {d_r, 1'b0};
    rem_sh  = {drem_r[RW-1:0], dq_r[NW-1]};
    rem_ge  = (rem_sh >= {1'b0, dvs});
    rem_sub = rem_sh - {1'b0, dvs};
    x_val   = (num_r <<< 1) + $signed({{(NW - DW){1'b0}}, d_r});
    dl2     = NW'(dl_r) <<< 1;
    rnz     = (drem_r[RW-1:0] != '0);
    if (dneg_r) begin
      qfix = -$signed(dq_r) - NW'(rnz);
      rfix = rnz ? (dvs - drem_r[RW-1:0]) : '0;
    end else begin
      qfix = $signed(dq_r);
      rfix = drem_r[RW-1:0];
    end
  end

  // ------------------------------------------------------ per-column datapath
  level_t hl, hk, j, l1, k1;
  logic signed [QW-1:0] jq, q_step;
  logic [RW:0] rsum;
  logic rcarry;
  logic ld, ud;
  level_t lf, lt, uf, ut;
  logic [1:0] lb_nxt, ub_nxt;
  logic [CAW-1:0] pm;
  logic at_end;

  always_comb begin
    hl = lvq_r ? level_t'(lram_q) : level_t'(LVL_HI);
    hk = uvq_r ? level_t'(uram_q) : level_t'(LVL_LO);
    jq = (n_r[NW-1] && (r_r == '0)) ? (q_r - QW'(1)) : q_r;
    j  = jq[FW-1:0];
    ld = 1'b0; ud = 1'b0;
    lf = '0; lt = '0; uf = '0; ut = '0;
    l1 = hl; k1 = hk; l2 = hl; k2 = hk;
    lb_nxt = lb_r; ub_nxt = ub_r;
    if (vert_r) begin
      if (j1_r < j2_r) begin
        if (j1_r < l1) begin
          ld = 1'b1; lf = j1_r; lt = lmin(l1, j2_r);
          k1 = lmax(k1, lt); l1 = j1_r;
        end
        l2 = l1; k2 = k1;
        if (j2_r > k1) begin
          ud = 1'b1; uf = lmax(k1, j1_r); ut = j2_r;
          l2 = lmin(l1, uf); k2 = j2_r;
        end
      end else if (j2_r < j1_r) begin
        if (j2_r < l1) begin
          ld = 1'b1; lf = lmin(j1_r, l1); lt = j2_r;
          k1 = lmax(k1, lf); l1 = j2_r;
        end
        l2 = l1; k2 = k1;
        if (j1_r > k1) begin
          ud = 1'b1; uf = j1_r; ut = lmax(k1, j2_r);
          l2 = lmin(l1, ut); k2 = j1_r;
        end
      end
    end else begin
      // Lower side first; the upper side sees its horizon updates.
      if (j <= hl) begin
        if (lb_r == SIDE_IN || lb_r == SIDE_OUT) begin
          ld = 1'b1; lf = (lb_r == SIDE_IN) ? pj_r : prev_l_r; lt = j;
          l1 = j; k1 = lmax(hk, j);
        end
        lb_nxt = SIDE_IN;
      end else begin
        if (lb_r == SIDE_IN) begin
          ld = 1'b1; lf = pj_r; lt = hl;
          k1 = lmax(hk, j);
        end
        lb_nxt = SIDE_OUT;
      end
      l2 = l1; k2 = k1;
      if (j >= k1) begin
        if (ub_r == SIDE_IN || ub_r == SIDE_OUT) begin
          ud = 1'b1; uf = (ub_r == SIDE_IN) ? pj_r : prev_k_r; ut = j;
          l2 = lmin(l1, j); k2 = j;
        end
        ub_nxt = SIDE_IN;
      end else begin
        if (ub_r == SIDE_IN) begin
          ud = 1'b1; uf = pj_r; ut = k1;
          l2 = lmin(l1, j);
        end
        ub_nxt = SIDE_OUT;
      end
    end
    pm     = inc_neg_r ? (c_r + CAW'(1)) : (c_r - CAW'(1));
    at_end = vert_r || (c_r == ce_r);
    rsum   = {1'b0, r_r} + {1'b0, rs_r};
    rcarry = (rsum >= {1'b0, dvs});
    q_step = q_r + qs_r + QW'(rcarry);
  end

  assign ram_we = (state_r == S_COL);

  fhl_ram #(.WIDTH(FW), .DEPTH(COLUMNS)) u_lower_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (c_r),
    .wdata (l2),
    .raddr (c_r),
    .rdata (lram_q)
  );

  fhl_ram #(.WIDTH(FW), .DEPTH(COLUMNS)) u_upper_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (c_r),
    .wdata (k2),
    .raddr (c_r),
    .rdata (uram_q)
  );

  // -------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept && in_kind) state_nxt = S_SETUP;
      S_SETUP: begin
        if (!in_grid) state_nxt = S_IDLE;
        else if (i1e == i2e) state_nxt = S_RD;
        else state_nxt = S_MUL1;
      end
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_DIV;
      S_DIV:   if (dcnt_r == KW'(NW - 1)) state_nxt = S_DFIX;
      S_DFIX:  state_nxt = dsel_r ? S_RD : S_DIV;
      S_RD:    state_nxt = S_COL;
      S_COL:   state_nxt = at_end ? S_IDLE : S_RD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      lval_r     <= '0;
      uval_r     <= '0;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_strobe <= ((state_r == S_SETUP) && !in_grid) || (state_r == S_COL);
      if (accept && !in_kind) begin
        lval_r <= '0;
        uval_r <= '0;
      end else if (state_r == S_COL) begin
        lval_r[c_r] <= 1'b1;
        uval_r[c_r] <= 1'b1;
      end
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      i1_r <= in_start_column;
      i2_r <= in_end_column;
      j1_r <= clamp_level(in_start_level);
      j2_r <= clamp_level(in_end_level);
    end
    case (state_r)
      S_SETUP: begin
        d_r       <= d_s;
        k_r       <= k_s;
        dl_r      <= DW'(j2_r) - DW'(j1_r);
        inc_neg_r <= !inc_pos;
        vert_r    <= (i1e == i2e);
        c_r       <= cs_s[CAW-1:0];
        ce_r      <= ce_s[CAW-1:0];
        first_r   <= 1'b1;
        lb_r      <= SIDE_NONE;
        ub_r      <= SIDE_NONE;
        // An off-grid segment reports one empty result.
        out_column      <= '0;
        out_from_column <= '0;
        out_lower_draw  <= 1'b0;
        out_lower_from  <= '0;
        out_lower_to    <= '0;
        out_upper_draw  <= 1'b0;
        out_upper_from  <= '0;
        out_upper_to    <= '0;
        out_last        <= 1'b1;
      end
      S_MUL1: prod_r <= mul_p;
      S_MUL2: num_r  <= NW'(prod_r) + NW'(mul_p);
      S_LOAD: begin
        n_r    <= num_r <<< 1;
        dneg_r <= x_val[NW-1];
        dq_r   <= x_val[NW-1] ? NW'(-x_val) : x_val;
        drem_r <= '0;
        dcnt_r <= '0;
        dsel_r <= 1'b0;
      end
      S_DIV: begin
        dq_r   <= {dq_r[NW-2:0], rem_ge};
        drem_r <= rem_ge ? rem_sub : rem_sh;
        dcnt_r <= dcnt_r + KW'(1);
      end
      S_DFIX: begin
        if (!dsel_r) begin
          q_r    <= qfix[QW-1:0];
          r_r    <= rfix;
          dneg_r <= dl2[NW-1];
          dq_r   <= dl2[NW-1] ? NW'(-dl2) : dl2;
          drem_r <= '0;
          dcnt_r <= '0;
          dsel_r <= 1'b1;
        end else begin
          qs_r <= qfix[QW-1:0];
          rs_r <= rfix;
        end
      end
      S_RD: begin
        lvq_r <= lval_r[c_r];
        uvq_r <= uval_r[c_r];
      end
      S_COL: begin
        out_column      <= CW'(c_r);
        out_from_column <= (first_r || vert_r) ? CW'(c_r) : CW'(pm);
        out_lower_draw  <= ld;
        out_lower_from  <= ld ? lf : '0;
        out_lower_to    <= ld ? lt : '0;
        out_upper_draw  <= ud;
        out_upper_from  <= ud ? uf : '0;
        out_upper_to    <= ud ? ut : '0;
        out_last        <= at_end;
        first_r  <= 1'b0;
        lb_r     <= lb_nxt;
        ub_r     <= ub_nxt;
        pj_r     <= j;
        prev_l_r <= l2;
        prev_k_r <= k2;
        c_r      <= inc_neg_r ? (c_r - CAW'(1)) : (c_r + CAW'(1));
        q_r      <= q_step;
        r_r      <= rcarry ? (rsum[RW-1:0] - dvs) : rsum[RW-1:0];
        n_r      <= n_r + dl2;
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  // A result only comes out of a segment that was being worked on.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy)) else $error("result without a busy item");

  // The block only becomes busy when an item was offered.
  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start)) else $error("busy without start");

  // The final result of an item is never followed directly by another.
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |=> !out_strobe) else $error("result right after last");
`endif
endmodule

FILE: hdl/fhl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the horizon stores; depends on nothing else.
`timescale 1ns / 1ps
module fhl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
